// ===== sv/mmad_pkg.sv =====
// Shared constants for the min/max/average decimator: register map, field widths, defaults.
package mmad_pkg;

    // parameter defaults
    localparam int D_MAX_CHANNELS = 8;
    localparam int D_MAX_BINS     = 4096;
    localparam int D_SAMPLE_WIDTH = 16;

    // register field widths
    localparam int CNT_W = 16;   // sample_count
    localparam int BC_W  = 13;   // bin_count
    localparam int CC_W  = 4;    // channel_count

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(2);

endpackage

// ===== sv/minmax_average_decimator_top.sv =====
// Min/max/average decimator: per-channel bin statistics held in a channel-indexed RAM.
//
//  channel   direction  handshake                          payload
//  -------   ---------  ---------------------------------  ----------------------------------
//  sample    in         i_sample_valid / o_sample_ready    i_sample
//  result    out        o_result_valid / i_result_ready    bin/channel/avg/min/max/global/last
//  config    in         i_cfg_we (no wait)                 i_cfg_index, i_cfg_data
//
//  A beat that does not close a bin passes through RAM read, then modify and write back.
//  A bin-closing beat then runs the radix-2 divider for the average, which retires one
//  quotient bit per cycle, before its result goes to the output register.
//  After a register write the same divider forms sample_count / bin_count; o_sample_ready
//  stays low until it is done. Reset is synchronous, active low.
//  A result waiting in the output register does not block the next sample beat; only a
//  new result waits for the output register to free up.
module minmax_average_decimator_top #(
    parameter int MAX_CHANNELS = mmad_pkg::D_MAX_CHANNELS,
    parameter int MAX_BINS     = mmad_pkg::D_MAX_BINS,
    parameter int SAMPLE_WIDTH = mmad_pkg::D_SAMPLE_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_we,
    input  logic [mmad_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mmad_pkg::CFG_W-1:0]            i_cfg_data,

    input  logic                                  i_sample_valid,
    output logic                                  o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,

    output logic                                  o_result_valid,
    input  logic                                  i_result_ready,
    output logic [$clog2(MAX_BINS)-1:0]           o_bin_index,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] o_channel,
    output logic signed [SAMPLE_WIDTH-1:0]        o_average,
    output logic signed [SAMPLE_WIDTH-1:0]        o_bin_min,
    output logic signed [SAMPLE_WIDTH-1:0]        o_bin_max,
    output logic signed [SAMPLE_WIDTH-1:0]        o_global_min,
    output logic signed [SAMPLE_WIDTH-1:0]        o_global_max,
    output logic                                  o_is_last
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int CNT_W = mmad_pkg::CNT_W;
    localparam int BC_W  = mmad_pkg::BC_W;
    localparam int CC_W  = mmad_pkg::CC_W;
    localparam int MAG_W = SW + CNT_W;      // |sum| of a full-length bin fits here
    localparam int SUM_W = MAG_W + 1;
    localparam int ENT_W = 2 * SW + SUM_W;  // {min, max, sum}
    localparam int DC_W  = $clog2(MAG_W + 1);

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RMW   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;
    localparam logic [2:0] S_CLOAD = 3'd4;
    localparam logic [2:0] S_CDIV  = 3'd5;

    // control state
    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_cfg_samples;
    logic [BC_W-1:0]  r_cfg_bins;
    logic [CC_W-1:0]  r_cfg_chans;
    logic [CNT_W-1:0] r_q;        // samples per bin, integer part
    logic [BC_W-1:0]  r_rem;      // samples per bin, fractional numerator
    logic [BC_W-1:0]  r_acc;      // running fraction of the current bin end
    logic [CH_W-1:0]  r_chan;
    logic [CNT_W-1:0] r_sidx;
    logic [BIN_W-1:0] r_bin;
    logic [CNT_W-1:0] r_bstart;
    logic [CNT_W-1:0] r_bend;
    logic signed [SW-1:0] r_run_min;
    logic signed [SW-1:0] r_run_max;
    logic             r_out_valid;

    // per-channel statistics RAM
    logic [ENT_W-1:0] r_mem [MAX_CHANNELS];
    logic [ENT_W-1:0] r_rd_data;

    // context of the beat in flight
    logic signed [SW-1:0] r_ctx_sample;
    logic [CH_W-1:0]      r_ctx_ch;
    logic                 r_ctx_first;
    logic                 r_ctx_close;
    logic [BIN_W-1:0]     r_ctx_bin;
    logic                 r_ctx_last;
    logic signed [SW-1:0] r_ctx_gmin;
    logic signed [SW-1:0] r_ctx_gmax;
    logic [CNT_W-1:0]     r_ctx_len;
    logic signed [SW-1:0] r_res_min;
    logic signed [SW-1:0] r_res_max;

    // shared restoring divider
    logic [MAG_W-1:0] r_dq;
    logic [CNT_W-1:0] r_drem;
    logic [CNT_W-1:0] r_ddiv;
    logic [DC_W-1:0]  r_dcnt;
    logic             r_dneg;

    // output register
    logic [BIN_W-1:0]     r_o_bin;
    logic [CH_W-1:0]      r_o_ch;
    logic signed [SW-1:0] r_o_avg;
    logic signed [SW-1:0] r_o_min;
    logic signed [SW-1:0] r_o_max;
    logic signed [SW-1:0] r_o_gmin;
    logic signed [SW-1:0] r_o_gmax;
    logic                 r_o_last;

    // effective register values
    logic [CNT_W-1:0] eff_samples;
    logic [BC_W-1:0]  eff_bins;
    logic [CC_W-1:0]  eff_chans;
    logic [CNT_W-1:0] num_bins;

    always_comb begin
        eff_samples = (r_cfg_samples == '0) ? CNT_W'(1) : r_cfg_samples;
        if (r_cfg_bins == '0) begin
            eff_bins = BC_W'(1);
        end else if (int'(r_cfg_bins) > MAX_BINS) begin
            eff_bins = BC_W'(MAX_BINS);
        end else begin
            eff_bins = r_cfg_bins;
        end
        if (r_cfg_chans == '0) begin
            eff_chans = CC_W'(1);
        end else if (int'(r_cfg_chans) > MAX_CHANNELS) begin
            eff_chans = CC_W'(MAX_CHANNELS);
        end else begin
            eff_chans = r_cfg_chans;
        end
        num_bins = (CNT_W'(eff_bins) < eff_samples) ? CNT_W'(eff_bins) : eff_samples;
    end

    // config decode
    logic cfg_hit;
    assign cfg_hit = i_cfg_we && (i_cfg_index == mmad_pkg::REG_SAMPLE_COUNT ||
                                  i_cfg_index == mmad_pkg::REG_BIN_COUNT ||
                                  i_cfg_index == mmad_pkg::REG_CHANNEL_COUNT);

    // accept-side decisions
    logic                 in_accept;
    logic                 first;
    logic                 closes;
    logic                 last_chan;
    logic                 last_bin;
    logic [CNT_W:0]       sidx_inc;
    logic signed [SW-1:0] n_run_min;
    logic signed [SW-1:0] n_run_max;
    logic [BC_W:0]        acc_sum;
    logic                 carry;
    logic [BC_W-1:0]      n_acc;
    logic [CNT_W-1:0]     n_bend;

    assign o_sample_ready = (r_state == S_IDLE);
    assign in_accept      = i_sample_valid && o_sample_ready;

    always_comb begin
        sidx_inc  = {1'b0, r_sidx} + 1'b1;
        first     = (r_sidx == r_bstart);
        closes    = (sidx_inc == {1'b0, r_bend});
        last_chan = ((int'(r_chan) + 1) == int'(eff_chans));
        last_bin  = ((int'(r_bin) + 1) >= int'(num_bins));
        n_run_min = (i_sample < r_run_min) ? i_sample : r_run_min;
        n_run_max = (i_sample > r_run_max) ? i_sample : r_run_max;
        // next bin end = floor((bin + 2) * N / W), kept as integer part plus fraction
        acc_sum   = {1'b0, r_acc} + {1'b0, r_rem};
        carry     = (acc_sum >= {1'b0, eff_bins});
        n_acc     = carry ? BC_W'(acc_sum - {1'b0, eff_bins}) : acc_sum[BC_W-1:0];
        n_bend    = r_bend + r_q + CNT_W'(carry);
    end

    // read-modify-write of the channel entry
    logic signed [SW-1:0]    old_min;
    logic signed [SW-1:0]    old_max;
    logic signed [SUM_W-1:0] old_sum;
    logic signed [SW-1:0]    upd_min;
    logic signed [SW-1:0]    upd_max;
    logic signed [SUM_W-1:0] upd_sum;
    logic signed [SUM_W-1:0] sum_abs;

    always_comb begin
        old_min = r_rd_data[ENT_W-1 -: SW];
        old_max = r_rd_data[ENT_W-SW-1 -: SW];
        old_sum = r_rd_data[SUM_W-1:0];
        if (r_ctx_first) begin
            upd_min = r_ctx_sample;
            upd_max = r_ctx_sample;
            upd_sum = SUM_W'(r_ctx_sample);
        end else begin
            upd_min = (r_ctx_sample < old_min) ? r_ctx_sample : old_min;
            upd_max = (r_ctx_sample > old_max) ? r_ctx_sample : old_max;
            upd_sum = old_sum + SUM_W'(r_ctx_sample);
        end
        sum_abs = upd_sum[SUM_W-1] ? -upd_sum : upd_sum;
    end

    // one quotient bit per cycle
    logic [CNT_W:0]   rem_sh;
    logic             rem_ge;
    logic [CNT_W-1:0] rem_step;
    logic [MAG_W-1:0] dq_step;
    logic             div_last;
    logic [MAG_W-1:0] avg_full;

    always_comb begin
        rem_sh   = {r_drem, r_dq[MAG_W-1]};
        rem_ge   = (rem_sh >= {1'b0, r_ddiv});
        rem_step = rem_ge ? CNT_W'(rem_sh - {1'b0, r_ddiv}) : rem_sh[CNT_W-1:0];
        dq_step  = {r_dq[MAG_W-2:0], rem_ge};
        div_last = (r_dcnt == DC_W'(MAG_W - 1));
        avg_full = r_dneg ? (~r_dq + 1'b1) : r_dq;
    end

    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_result_ready);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg_samples <= CNT_W'(1);
            r_cfg_bins    <= BC_W'(1);
            r_cfg_chans   <= CC_W'(1);
            r_q           <= CNT_W'(1);
            r_rem         <= '0;
            r_acc         <= '0;
            r_chan        <= '0;
            r_sidx        <= '0;
            r_bin         <= '0;
            r_bstart      <= '0;
            r_bend        <= CNT_W'(1);
            r_run_min     <= SMAX;
            r_run_max     <= SMIN;
            r_out_valid   <= 1'b0;
        end else begin
            if (out_load && !cfg_hit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_result_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_hit) begin
                unique case (i_cfg_index)
                    mmad_pkg::REG_SAMPLE_COUNT:  r_cfg_samples <= i_cfg_data[CNT_W-1:0];
                    mmad_pkg::REG_BIN_COUNT:     r_cfg_bins    <= i_cfg_data[BC_W-1:0];
                    mmad_pkg::REG_CHANNEL_COUNT: r_cfg_chans   <= i_cfg_data[CC_W-1:0];
                    default: ;
                endcase
                r_chan  <= '0;
                r_state <= S_CLOAD;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_accept) begin
                            r_state <= S_RMW;
                            if (last_chan) begin
                                r_chan <= '0;
                                if (sidx_inc >= {1'b0, eff_samples}) begin
                                    // end of run: start over
                                    r_sidx    <= '0;
                                    r_bin     <= '0;
                                    r_bstart  <= '0;
                                    r_bend    <= r_q;
                                    r_acc     <= r_rem;
                                    r_run_min <= SMAX;
                                    r_run_max <= SMIN;
                                end else begin
                                    r_sidx    <= sidx_inc[CNT_W-1:0];
                                    r_run_min <= n_run_min;
                                    r_run_max <= n_run_max;
                                    if (sidx_inc >= {1'b0, r_bend}) begin
                                        r_bin    <= r_bin + 1'b1;
                                        r_bstart <= r_bend;
                                        r_bend   <= n_bend;
                                        r_acc    <= n_acc;
                                    end
                                end
                            end else begin
                                r_chan    <= r_chan + 1'b1;
                                r_run_min <= n_run_min;
                                r_run_max <= n_run_max;
                            end
                        end
                    end
                    S_RMW: begin
                        r_state <= r_ctx_close ? S_DIV : S_IDLE;
                    end
                    S_DIV: begin
                        if (div_last) begin
                            r_state <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        if (out_load) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_CLOAD: begin
                        r_state <= S_CDIV;
                    end
                    S_CDIV: begin
                        if (div_last) begin
                            if (eff_samples > CNT_W'(eff_bins)) begin
                                r_q   <= dq_step[CNT_W-1:0];
                                r_rem <= rem_step[BC_W-1:0];
                                r_bend <= dq_step[CNT_W-1:0];
                                r_acc  <= rem_step[BC_W-1:0];
                            end else begin
                                r_q    <= CNT_W'(1);
                                r_rem  <= '0;
                                r_bend <= CNT_W'(1);
                                r_acc  <= '0;
                            end
                            r_chan    <= '0;
                            r_sidx    <= '0;
                            r_bin     <= '0;
                            r_bstart  <= '0;
                            r_run_min <= SMAX;
                            r_run_max <= SMIN;
                            r_state   <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    // statistics RAM: read on accept, write back in the cycle after, in S_RMW
    always_ff @(posedge i_clk) begin
        if (r_state == S_RMW) begin
            r_mem[r_ctx_ch] <= {upd_min, upd_max, upd_sum};
        end
        if (in_accept) begin
            r_rd_data <= r_mem[r_chan];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ctx_sample <= i_sample;
            r_ctx_ch     <= r_chan;
            r_ctx_first  <= first;
            r_ctx_close  <= closes;
            r_ctx_bin    <= r_bin;
            r_ctx_last   <= last_bin && last_chan;
            r_ctx_gmin   <= n_run_min;
            r_ctx_gmax   <= n_run_max;
            r_ctx_len    <= r_bend - r_bstart;
        end

        if (r_state == S_RMW) begin
            r_res_min <= upd_min;
            r_res_max <= upd_max;
            r_dq      <= sum_abs[MAG_W-1:0];
            r_dneg    <= upd_sum[SUM_W-1];
            r_ddiv    <= r_ctx_len;
            r_drem    <= '0;
            r_dcnt    <= '0;
        end else if (r_state == S_CLOAD) begin
            r_dq      <= MAG_W'(eff_samples);
            r_dneg    <= 1'b0;
            r_ddiv    <= CNT_W'(eff_bins);
            r_drem    <= '0;
            r_dcnt    <= '0;
        end else if (r_state == S_DIV || r_state == S_CDIV) begin
            r_dq      <= dq_step;
            r_drem    <= rem_step;
            r_dcnt    <= r_dcnt + 1'b1;
        end

        if (out_load) begin
            r_o_bin  <= r_ctx_bin;
            r_o_ch   <= r_ctx_ch;
            r_o_avg  <= avg_full[SW-1:0];
            r_o_min  <= r_res_min;
            r_o_max  <= r_res_max;
            r_o_gmin <= r_ctx_gmin;
            r_o_gmax <= r_ctx_gmax;
            r_o_last <= r_ctx_last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_bin_index    = r_o_bin;
    assign o_channel      = r_o_ch;
    assign o_average      = r_o_avg;
    assign o_bin_min      = r_o_min;
    assign o_bin_max      = r_o_max;
    assign o_global_min   = r_o_gmin;
    assign o_global_max   = r_o_gmax;
    assign o_is_last      = r_o_last;

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (int'(r_chan) < int'(eff_chans)))
        else $error("channel counter beyond channel count");

    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_bstart < r_bend))
        else $error("bin start not below bin end");

    a_close_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW && r_ctx_close && !cfg_hit) |=> (r_state == S_DIV))
        else $error("bin close did not start the divider");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_CDIV) |-> (int'(r_dcnt) < MAG_W))
        else $error("divider step count overran");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> ($past(r_state) == S_OUT))
        else $error("result valid raised outside output load");

endmodule

// ===== dv/tb.sv =====
// Testbench for the min/max/average decimator: random and directed runs, checked per beat.
`timescale 1ns / 1ps

module tb;

    localparam int                             IDLE_LIMIT = 5000;
    localparam int                             CFG_PAUSE  = 48;   // divider latency plus margin
    localparam int                             ITEM_GOAL  = 925;  // directed part plus ~900 random
    localparam logic [mmad_pkg::CFG_IDX_W-1:0] REG_UNUSED = '1;
    localparam logic [15:0]                    SMP_MAX    = 16'h7FFF;
    localparam logic [15:0]                    SMP_MIN    = 16'h8000;

    typedef struct {
        logic [11:0]        bin_index;
        logic [2:0]         channel;
        logic signed [15:0] average;
        logic signed [15:0] bin_min;
        logic signed [15:0] bin_max;
        logic signed [15:0] global_min;
        logic signed [15:0] global_max;
        logic               is_last;
    } t_bin_result;

    // Predicts bin statistics from accepted samples and checks result beats in order.
    class t_bin_stats_scoreboard;
        int unsigned cfg_n, cfg_w, cfg_c;
        longint      ch_lo [mmad_pkg::D_MAX_CHANNELS];
        longint      ch_hi [mmad_pkg::D_MAX_CHANNELS];
        longint      ch_acc[mmad_pkg::D_MAX_CHANNELS];
        int unsigned samp_idx, chan_idx, bin_no, first_samp, end_samp;
        longint      run_lo, run_hi;
        t_bin_result expected_q[$];
        int unsigned mismatches;

        function new();
            cfg_n = 1;
            cfg_w = 1;
            cfg_c = 1;
            foreach (ch_lo[i]) begin
                ch_lo[i]  = 0;
                ch_hi[i]  = 0;
                ch_acc[i] = 0;
            end
            mismatches = 0;
            restart_run();
        endfunction

        function int unsigned eff_samples();
            return (cfg_n == 0) ? 1 : cfg_n;
        endfunction

        function int unsigned eff_bins();
            if (cfg_w == 0) return 1;
            if (cfg_w > mmad_pkg::D_MAX_BINS) return mmad_pkg::D_MAX_BINS;
            return cfg_w;
        endfunction

        function int unsigned eff_channels();
            if (cfg_c == 0) return 1;
            if (cfg_c > mmad_pkg::D_MAX_CHANNELS) return mmad_pkg::D_MAX_CHANNELS;
            return cfg_c;
        endfunction

        // exclusive end sample of a bin
        function int unsigned bin_end_of(int unsigned b);
            longint unsigned prod;
            if (eff_samples() > eff_bins()) begin
                prod = (longint'(b) + 1) * longint'(eff_samples());
                return 32'(prod / longint'(eff_bins()));
            end
            return b + 1;
        endfunction

        function void restart_run();
            samp_idx   = 0;
            chan_idx   = 0;
            bin_no     = 0;
            first_samp = 0;
            end_samp   = bin_end_of(0);
            run_lo     = 32767;
            run_hi     = -32768;
        endfunction

        function void write_reg(logic [mmad_pkg::CFG_IDX_W-1:0] idx,
                                logic [mmad_pkg::CFG_W-1:0] data);
            case (idx)
                mmad_pkg::REG_SAMPLE_COUNT:  cfg_n = 32'(data[mmad_pkg::CNT_W-1:0]);
                mmad_pkg::REG_BIN_COUNT:     cfg_w = 32'(data[mmad_pkg::BC_W-1:0]);
                mmad_pkg::REG_CHANNEL_COUNT: cfg_c = 32'(data[mmad_pkg::CC_W-1:0]);
                default:                     return;
            endcase
            restart_run();
        endfunction

        function void note_sample(logic signed [15:0] smp);
            int unsigned nch, nsamp, nbins, ch;
            longint      v;
            t_bin_result r;
            nch   = eff_channels();
            nsamp = eff_samples();
            nbins = (eff_bins() < nsamp) ? eff_bins() : nsamp;
            v     = longint'(smp);
            if (chan_idx >= nch) chan_idx = 0;
            ch = chan_idx;
            if (samp_idx == first_samp) begin
                ch_lo[ch]  = v;
                ch_hi[ch]  = v;
                ch_acc[ch] = v;
            end else begin
                if (v < ch_lo[ch]) ch_lo[ch] = v;
                if (v > ch_hi[ch]) ch_hi[ch] = v;
                ch_acc[ch] += v;
            end
            if (v < run_lo) run_lo = v;
            if (v > run_hi) run_hi = v;

            if (samp_idx + 1 == end_samp) begin
                r.bin_index  = bin_no[11:0];
                r.channel    = ch[2:0];
                r.average    = 16'(ch_acc[ch] / longint'(end_samp - first_samp));
                r.bin_min    = 16'(ch_lo[ch]);
                r.bin_max    = 16'(ch_hi[ch]);
                r.global_min = 16'(run_lo);
                r.global_max = 16'(run_hi);
                r.is_last    = (bin_no + 1 >= nbins) && (ch + 1 == nch);
                expected_q.push_back(r);
            end

            chan_idx = ch + 1;
            if (chan_idx >= nch) begin
                chan_idx = 0;
                samp_idx++;
                if (samp_idx >= nsamp) begin
                    restart_run();
                end else if (samp_idx >= end_samp) begin
                    bin_no++;
                    first_samp = end_samp;
                    end_samp   = bin_end_of(bin_no);
                end
            end
        endfunction

        function void check_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_bin_result got);
            t_bin_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: bin_index %0d channel %0d",
                       got.bin_index, got.channel);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            check_field("bin_index",  32'(want.bin_index),  32'(got.bin_index));
            check_field("channel",    32'(want.channel),    32'(got.channel));
            check_field("average",    32'(want.average),    32'(got.average));
            check_field("bin_min",    32'(want.bin_min),    32'(got.bin_min));
            check_field("bin_max",    32'(want.bin_max),    32'(got.bin_max));
            check_field("global_min", 32'(want.global_min), 32'(got.global_min));
            check_field("global_max", 32'(want.global_max), 32'(got.global_max));
            check_field("is_last",    32'(want.is_last),    32'(got.is_last));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [mmad_pkg::CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [mmad_pkg::CFG_W-1:0]      i_cfg_data     = '0;
    logic                            i_sample_valid = 1'b0;
    logic                            o_sample_ready;
    logic signed [15:0]              i_sample       = '0;
    logic                            o_result_valid;
    logic                            i_result_ready = 1'b0;
    logic [11:0]                     o_bin_index;
    logic [2:0]                      o_channel;
    logic signed [15:0]              o_average;
    logic signed [15:0]              o_bin_min;
    logic signed [15:0]              o_bin_max;
    logic signed [15:0]              o_global_min;
    logic signed [15:0]              o_global_max;
    logic                            o_is_last;

    t_bin_stats_scoreboard sb;
    t_bin_result           seen;
    bit                    sender_gaps     = 1'b1;
    bit                    receiver_stalls = 1'b1;
    int                    stall_left      = 0;
    int                    idle_cycles     = 0;
    int unsigned           samples_sent    = 0;

    minmax_average_decimator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_bin_index    (o_bin_index),
        .o_channel      (o_channel),
        .o_average      (o_average),
        .o_bin_min      (o_bin_min),
        .o_bin_max      (o_bin_max),
        .o_global_min   (o_global_min),
        .o_global_max   (o_global_max),
        .o_is_last      (o_is_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return $urandom_range(1, 2);
        if (pick < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            2, 3:    return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_result_ready <= 1'b0;
            stall_left     <= 0;
        end else if (stall_left != 0) begin
            i_result_ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end else begin
            i_result_ready <= 1'b1;
            if (receiver_stalls && $urandom_range(0, 4) == 0) stall_left <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid && i_result_ready) begin
                seen.bin_index  = o_bin_index;
                seen.channel    = o_channel;
                seen.average    = o_average;
                seen.bin_min    = o_bin_min;
                seen.bin_max    = o_bin_max;
                seen.global_min = o_global_min;
                seen.global_max = o_global_max;
                seen.is_last    = o_is_last;
                sb.check_result(seen);
            end
            if (i_cfg_we) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_sample_valid && o_sample_ready) sb.note_sample(i_sample);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_sample_valid && o_sample_ready) ||
            (o_result_valid && i_result_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // valid stays up across back-to-back beats; only dropped when a gap follows
    task automatic push_sample(input logic [15:0] v);
        int gap;
        gap = (sender_gaps && $urandom_range(0, 1) == 0) ? idle_len() : 0;
        if (gap != 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= v;
        do @(posedge i_clk); while (!o_sample_ready);
        samples_sent++;
    endtask

    task automatic drain_results();
        i_sample_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // pause first so a bin-closing beat with no result has finished
    task automatic write_reg(input logic [mmad_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mmad_pkg::CFG_W-1:0] data);
        repeat (CFG_PAUSE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_geometry(input logic [15:0] n_data, input logic [15:0] w_data,
                                input logic [15:0] c_data);
        drain_results();
        write_reg(mmad_pkg::REG_SAMPLE_COUNT, n_data);
        write_reg(mmad_pkg::REG_BIN_COUNT, w_data);
        write_reg(mmad_pkg::REG_CHANNEL_COUNT, c_data);
    endtask

    initial begin
        int unsigned n, w, c, items, per_run, mid;
        bit          hold;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: one sample, one bin, one channel; every beat ends a run
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);

        // zero registers act as one; high data bits outside a field are dropped
        set_geometry(16'h0000, 16'hE000, 16'hFFF0);
        push_sample(16'h0001);
        push_sample(16'hFFFF);

        // bin_count and channel_count saturate
        set_geometry(16'h0001, 16'hFFFF, 16'h000F);
        for (int i = 0; i < 8; i++) push_sample(i[0] ? SMP_MIN : SMP_MAX);

        // two uneven bins over two channels, an unused-index write mid-run,
        // then wrap into the next run
        set_geometry(16'h0005, 16'h0002, 16'h0002);
        push_sample(SMP_MIN);
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample(16'hFFFF);
        push_sample(16'h0003);
        drain_results();
        write_reg(REG_UNUSED, 16'hFFFF);
        push_sample(16'hFFFD);
        push_sample(SMP_MAX);
        push_sample(16'h8001);
        push_sample(SMP_MAX);
        push_sample(16'h0000);
        push_sample(16'h0007);
        push_sample(16'hFFF9);
        push_sample(16'h0000);

        while (samples_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0: begin
                    n     = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(30000, 65535);
                    w     = $urandom_range(2048, 8191);
                    c     = $urandom_range(1, 3);
                    items = $urandom_range(40, 100);
                end
                1: begin
                    n = $urandom_range(1, 8);
                    w = $urandom_range(1000, 8191);
                    c = $urandom_range(0, 15);
                end
                default: begin
                    n = $urandom_range(0, 24);
                    w = $urandom_range(0, 24);
                    c = $urandom_range(0, 9);
                end
            endcase
            if (n < 30000) begin
                per_run = ((n == 0) ? 1 : n) * ((c == 0) ? 1 : (c > 8) ? 8 : c);
                items   = per_run * $urandom_range(1, 2) + $urandom_range(0, per_run);
                if (items > 200) items = 200;
            end
            set_geometry(n[15:0], {3'($urandom), w[12:0]}, {12'($urandom), c[3:0]});
            sender_gaps     = $urandom_range(0, 3) != 0;
            receiver_stalls = $urandom_range(0, 3) != 0;
            hold            = $urandom_range(0, 3) == 0;
            mid             = items / 2;
            for (int i = 0; i < items; i++) begin
                if (hold && i == mid) drain_results();
                push_sample(rand_sample());
            end
        end

        drain_results();
        repeat (CFG_PAUSE) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
